/* src/fbpa_pkg.sv */
// Shared widths, codes and interface types of the fixed block pool allocator.
package fbpa_pkg;

   localparam int OFF_W      = 24;
   localparam int OBJ_W      = 13;
   localparam int PER_CFG_W  = 9;
   localparam int LIVE_W     = 13;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 13;

   localparam logic [OFF_W-1:0]     OFFSET_MASK  = {OFF_W{1'b1}};
   localparam logic [OBJ_W-1:0]     OBJ_BYTES_RST = 13'd16;
   localparam logic [PER_CFG_W-1:0] PER_PAGE_RST  = 9'd64;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_OBJECT_BYTES     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OBJECTS_PER_PAGE = 8'd1;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_EXHAUSTED   = 2'd1,
      STATUS_BAD_ADDR    = 2'd2,
      STATUS_DOUBLE_FREE = 2'd3
   } status_type;

   typedef struct packed {
      logic             start;
      logic [OFF_W-1:0] dividend;
      logic [OBJ_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [OFF_W-1:0] quotient;
      logic [OBJ_W-1:0] remainder;
   } div_rsp_type;

endpackage

/* src/fbpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module fbpa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/fbpa_div.sv */
// Restoring divider: one quotient bit per cycle for a byte offset over the slot size.
module fbpa_div (
   input  logic                clock,
   input  logic                reset,
   input  fbpa_pkg::div_req_type req,
   output fbpa_pkg::div_rsp_type rsp
);
   import fbpa_pkg::*;

   localparam int STEP_W = $clog2(OFF_W);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [OFF_W-1:0]  quo_ff, quo_in;
   logic [OBJ_W-1:0]  rem_ff, rem_in;
   logic [OBJ_W-1:0]  dvs_ff, dvs_in;
   logic [OBJ_W:0]    shifted;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quo_ff[OFF_W-1]};
      if (req.start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(OFF_W - 1);
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (run_ff) begin
         // The partial remainder stays below the divisor, so it fits OBJ_W bits.
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = OBJ_W'(shifted - {1'b0, dvs_ff});
            quo_in = {quo_ff[OFF_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[OBJ_W-1:0];
            quo_in = {quo_ff[OFF_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

/* src/fixed_block_pool_allocator.sv */
// Fixed-size slot pool allocator: a LIFO of freed slots, fresh pages and an in-use bitmap.
//
// One operation at a time. An allocate reads the freed-slot stack memory, then forms the slot
// offset and writes the in-use bitmap. A free runs the bit-serial divider that turns the
// byte offset into a slot index, followed by a read-modify-write of the bitmap memory
// (skipped when the address is invalid). Each result word is shown for one cycle with
// rsp_valid and the receiver cannot stall it; busy is low during that cycle, so the next
// word can be accepted at once. After reset and after every configuration write the
// bitmap is cleared in a pass over every slot of the pool, during which busy stays high.
module fixed_block_pool_allocator #(
   parameter int MAX_PAGES          = 16,
   parameter int MAX_SLOTS_PER_PAGE = 256,
   parameter int MAX_OBJECT_BYTES   = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [fbpa_pkg::OFF_W-1:0]          req_free_offset,
   output logic                                rsp_valid,
   output logic [fbpa_pkg::OFF_W-1:0]          rsp_given_offset,
   output logic [1:0]                          rsp_status,
   output logic [fbpa_pkg::LIVE_W-1:0]         rsp_outstanding,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fbpa_pkg::*;

   localparam int POOL_SLOTS = MAX_PAGES * MAX_SLOTS_PER_PAGE;
   localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
   localparam int PAGE_W     = $clog2(MAX_PAGES + 1);
   localparam int PER_W      = $clog2(MAX_SLOTS_PER_PAGE + 1);
   localparam int PROD_W     = CNT_W + OBJ_W;
   localparam int EXT_W      = (PROD_W > OFF_W) ? PROD_W : OFF_W + 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC,
      S_DIV,
      S_CHECK
   } state_type;

   state_type         state_ff, state_in;
   logic [OBJ_W-1:0]     obj_bytes_ff, obj_bytes_in;
   logic [PER_CFG_W-1:0] per_page_ff, per_page_in;
   logic [CNT_W-1:0]     depth_ff, depth_in;
   logic [PAGE_W-1:0]    pages_ff, pages_in;
   logic [PER_W-1:0]     fresh_ff, fresh_in;
   logic [LIVE_W-1:0]    live_ff, live_in;
   logic [CNT_W-1:0]     open_base_ff, open_base_in;
   logic [CNT_W-1:0]     open_slots_ff, open_slots_in;
   logic [SLOT_W-1:0]    clear_cnt_ff, clear_cnt_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]     rsp_given_ff, rsp_given_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic [OBJ_W-1:0]  bytes_eff;
   logic [PER_W-1:0]  per_eff;
   logic              accept;
   logic              from_stack, fresh_ok, page_ok, have, fits;
   logic [CNT_W-1:0]  cand;
   logic [EXT_W-1:0]  prod;
   logic              bad_addr;

   logic              stack_we;
   logic [SLOT_W-1:0] stack_waddr, stack_raddr;
   logic [SLOT_W-1:0] stack_wdata, stack_rdata;
   logic              map_we;
   logic [SLOT_W-1:0] map_waddr, map_raddr;
   logic              map_wdata, map_rdata;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // Zero acts as one; oversized values are capped at the pool's limits.
   always_comb begin
      if (obj_bytes_ff == '0) begin
         bytes_eff = OBJ_W'(1);
      end else if (32'(obj_bytes_ff) > 32'(MAX_OBJECT_BYTES)) begin
         bytes_eff = OBJ_W'(MAX_OBJECT_BYTES);
      end else begin
         bytes_eff = obj_bytes_ff;
      end
      if (per_page_ff == '0) begin
         per_eff = PER_W'(1);
      end else if (32'(per_page_ff) > 32'(MAX_SLOTS_PER_PAGE)) begin
         per_eff = PER_W'(MAX_SLOTS_PER_PAGE);
      end else begin
         per_eff = PER_W'(per_page_ff);
      end
   end

   assign accept = start && (state_ff == S_IDLE);

   // Allocation candidate, valid in S_ALLOC once the stack read has returned.
   assign from_stack = (depth_ff != '0);
   assign fresh_ok   = (fresh_ff < per_eff);
   assign page_ok    = (pages_ff < PAGE_W'(MAX_PAGES));
   assign have       = from_stack || fresh_ok || page_ok;
   assign cand       = from_stack ? CNT_W'(stack_rdata)
                     : fresh_ok   ? open_base_ff + CNT_W'(fresh_ff)
                     :              open_slots_ff;
   assign prod       = EXT_W'(cand) * EXT_W'(bytes_eff);
   assign fits       = (cand < CNT_W'(POOL_SLOTS)) && (prod <= EXT_W'(OFFSET_MASK));

   // The open area is open_slots whole slots, so the quotient alone bounds the offset.
   assign bad_addr = (div_rsp.remainder != '0) ||
                     (div_rsp.quotient >= OFF_W'(open_slots_ff));

   assign stack_raddr = SLOT_W'(depth_ff - CNT_W'(1));
   assign map_raddr   = div_rsp.quotient[SLOT_W-1:0];

   always_comb begin
      state_in      = state_ff;
      obj_bytes_in  = obj_bytes_ff;
      per_page_in   = per_page_ff;
      depth_in      = depth_ff;
      pages_in      = pages_ff;
      fresh_in      = fresh_ff;
      live_in       = live_ff;
      open_base_in  = open_base_ff;
      open_slots_in = open_slots_ff;
      clear_cnt_in  = clear_cnt_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_given_in  = rsp_given_ff;
      rsp_status_in = rsp_status_ff;
      stack_we      = 1'b0;
      stack_waddr   = SLOT_W'(depth_ff);
      stack_wdata   = idx_ff;
      map_we        = 1'b0;
      map_waddr     = idx_ff;
      map_wdata     = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = req_free_offset;
      div_req.divisor  = bytes_eff;

      case (state_ff)
         S_CLEAR: begin
            map_we        = 1'b1;
            map_waddr     = clear_cnt_ff;
            map_wdata     = 1'b0;
            depth_in      = '0;
            pages_in      = PAGE_W'(1);
            fresh_in      = '0;
            live_in       = '0;
            open_base_in  = '0;
            open_slots_in = CNT_W'(per_eff);
            if (clear_cnt_ff == SLOT_W'(POOL_SLOTS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clear_cnt_in = clear_cnt_ff + SLOT_W'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_FREE) begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV;
               end else begin
                  state_in = S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (have && fits) begin
               if (from_stack) begin
                  depth_in = depth_ff - CNT_W'(1);
               end else if (fresh_ok) begin
                  fresh_in = fresh_ff + PER_W'(1);
               end else begin
                  pages_in      = pages_ff + PAGE_W'(1);
                  fresh_in      = PER_W'(1);
                  open_base_in  = open_slots_ff;
                  open_slots_in = open_slots_ff + CNT_W'(per_eff);
               end
               map_we        = 1'b1;
               map_waddr     = cand[SLOT_W-1:0];
               map_wdata     = 1'b1;
               live_in       = live_ff + LIVE_W'(1);
               rsp_given_in  = prod[OFF_W-1:0];
               rsp_status_in = STATUS_OK;
            end else begin
               rsp_given_in  = '0;
               rsp_status_in = STATUS_EXHAUSTED;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               idx_in = div_rsp.quotient[SLOT_W-1:0];
               if (bad_addr) begin
                  rsp_valid_in  = 1'b1;
                  rsp_given_in  = '0;
                  rsp_status_in = STATUS_BAD_ADDR;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            rsp_valid_in = 1'b1;
            rsp_given_in = '0;
            state_in     = S_IDLE;
            if (!map_rdata) begin
               rsp_status_in = STATUS_DOUBLE_FREE;
            end else begin
               map_we    = 1'b1;
               map_waddr = idx_ff;
               map_wdata = 1'b0;
               if (depth_ff < CNT_W'(POOL_SLOTS)) begin
                  stack_we = 1'b1;
                  depth_in = depth_ff + CNT_W'(1);
               end
               live_in       = live_ff - LIVE_W'(1);
               rsp_status_in = STATUS_OK;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      // A register write rebuilds the pool from scratch under the new geometry.
      if (csr_valid) begin
         if (csr_index == REG_OBJECT_BYTES) begin
            obj_bytes_in = csr_wdata[OBJ_W-1:0];
            state_in     = S_CLEAR;
            clear_cnt_in = '0;
         end else if (csr_index == REG_OBJECTS_PER_PAGE) begin
            per_page_in  = csr_wdata[PER_CFG_W-1:0];
            state_in     = S_CLEAR;
            clear_cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         obj_bytes_ff  <= OBJ_BYTES_RST;
         per_page_ff   <= PER_PAGE_RST;
         depth_ff      <= '0;
         pages_ff      <= PAGE_W'(1);
         fresh_ff      <= '0;
         live_ff       <= '0;
         open_base_ff  <= '0;
         open_slots_ff <= '0;
         clear_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         obj_bytes_ff  <= obj_bytes_in;
         per_page_ff   <= per_page_in;
         depth_ff      <= depth_in;
         pages_ff      <= pages_in;
         fresh_ff      <= fresh_in;
         live_ff       <= live_in;
         open_base_ff  <= open_base_in;
         open_slots_ff <= open_slots_in;
         clear_cnt_ff  <= clear_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      rsp_given_ff  <= rsp_given_in;
      rsp_status_ff <= rsp_status_in;
   end

   fbpa_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (POOL_SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   fbpa_ram #(
      .WIDTH (1),
      .DEPTH (POOL_SLOTS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   fbpa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_given_offset = rsp_given_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_outstanding  = live_ff;

endmodule

/* tb/sv/fixed_block_pool_allocator_test.sv */
// Self-checking testbench of the fixed block pool allocator with its own pool predictor.
`timescale 1ns / 100ps

module fixed_block_pool_allocator_test;
   import fbpa_pkg::*;

   localparam int MAX_PAGES          = 16;
   localparam int MAX_SLOTS_PER_PAGE = 256;
   localparam int MAX_OBJECT_BYTES   = 4096;
   localparam int POOL_SLOTS         = MAX_PAGES * MAX_SLOTS_PER_PAGE;
   localparam int CYCLE_LIMIT        = 1000000;
   localparam int RANDOM_PHASES      = 8;
   localparam int PHASE_WORDS        = 150;
   localparam int DRAIN_CYCLES       = 40;
   localparam int DUE_DEPTH          = 8;

   // Register index that names no register; a write to it must leave the pool alone.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_FIRST = 8'd2;

   typedef struct packed {
      logic [OFF_W-1:0]  given;
      status_type        status;
      logic [LIVE_W-1:0] outstanding;
   } slot_reply_type;

   typedef struct packed {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_data;
      logic                  func;
      logic [OFF_W-1:0]      off;
      bit                    typed;
      slot_reply_type        reply;
   } plan_row_type;

   // Directed opening: default geometry of 16-byte slots and 64 slots per page, then a
   // single-slot page of capped 4096-byte slots.
   localparam int PLAN_ROWS = 24;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{1'b0, 8'd0, 13'd0, FUNC_ALLOC, 24'hABCDEF, 1'b1, '{24'd0,    STATUS_OK,          13'd1}},
      '{1'b0, 8'd0, 13'd0, FUNC_ALLOC, 24'h000000, 1'b1, '{24'd16,   STATUS_OK,          13'd2}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'd16,     1'b1, '{24'd0,    STATUS_OK,          13'd1}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'd16,     1'b1, '{24'd0,    STATUS_DOUBLE_FREE, 13'd1}},
      '{1'b0, 8'd0, 13'd0, FUNC_ALLOC, 24'h555555, 1'b1, '{24'd16,   STATUS_OK,          13'd2}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'd8,      1'b1, '{24'd0,    STATUS_BAD_ADDR,    13'd2}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'd1024,   1'b1, '{24'd0,    STATUS_BAD_ADDR,    13'd2}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'hFFFFFF, 1'b1, '{24'd0,    STATUS_BAD_ADDR,    13'd2}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'd32,     1'b1, '{24'd0,    STATUS_DOUBLE_FREE, 13'd2}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'd0,      1'b1, '{24'd0,    STATUS_OK,          13'd1}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'd16,     1'b1, '{24'd0,    STATUS_OK,          13'd0}},
      '{1'b0, 8'd0, 13'd0, FUNC_ALLOC, 24'd0,      1'b1, '{24'd16,   STATUS_OK,          13'd1}},
      '{1'b0, 8'd0, 13'd0, FUNC_ALLOC, 24'd0,      1'b1, '{24'd0,    STATUS_OK,          13'd2}},
      '{1'b0, 8'd0, 13'd0, FUNC_ALLOC, 24'hFFFFFF, 1'b0, '{24'd0,    STATUS_OK,          13'd0}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'd1008,   1'b1, '{24'd0,    STATUS_DOUBLE_FREE, 13'd3}},
      '{1'b1, REG_OBJECTS_PER_PAGE, 13'h1E00, FUNC_ALLOC, 24'd0, 1'b0,
        '{24'd0, STATUS_OK, 13'd0}},
      '{1'b1, REG_OBJECT_BYTES, 13'h1FFF, FUNC_ALLOC, 24'd0, 1'b0,
        '{24'd0, STATUS_OK, 13'd0}},
      '{1'b0, 8'd0, 13'd0, FUNC_ALLOC, 24'd0,      1'b1, '{24'd0,    STATUS_OK,          13'd1}},
      '{1'b0, 8'd0, 13'd0, FUNC_ALLOC, 24'd0,      1'b1, '{24'd4096, STATUS_OK,          13'd2}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'd8192,   1'b1, '{24'd0,    STATUS_BAD_ADDR,    13'd2}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'd4095,   1'b1, '{24'd0,    STATUS_BAD_ADDR,    13'd2}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'd4096,   1'b0, '{24'd0,    STATUS_OK,          13'd0}},
      '{1'b0, 8'd0, 13'd0, FUNC_ALLOC, 24'd0,      1'b0, '{24'd0,    STATUS_OK,          13'd0}},
      '{1'b0, 8'd0, 13'd0, FUNC_FREE,  24'h800000, 1'b0, '{24'd0,    STATUS_OK,          13'd0}}
   };

   localparam int PHASE_BYTES [RANDOM_PHASES] = '{1, 4096, 0, 8191, 24, 7, 100, 3};
   localparam int PHASE_PER   [RANDOM_PHASES] = '{1, 256, 2, 511, 3, 5, 1, 40};
   localparam int PHASE_IDLE  [RANDOM_PHASES] = '{0, 69, 23, 0, 69, 23, 0, 69};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_func;
   logic [OFF_W-1:0]      req_free_offset;
   logic                  rsp_valid;
   logic [OFF_W-1:0]      rsp_given_offset;
   logic [1:0]            rsp_status;
   logic [LIVE_W-1:0]     rsp_outstanding;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Typed expectation for the word now offered, used instead of the prediction.
   bit                    typed_now;
   slot_reply_type        typed_reply;

   // Pool image kept by the predictor.
   logic [OBJ_W-1:0]      cfg_bytes;
   logic [PER_CFG_W-1:0]  cfg_per;
   logic [11:0]           freed_slots [POOL_SLOTS];
   int unsigned           freed_top;
   bit                    slot_live [POOL_SLOTS];
   int unsigned           open_pages;
   int unsigned           fresh_used;
   logic [LIVE_W-1:0]     live_slots;

   // Replies still owed by the block, oldest at due_head.
   slot_reply_type        due_ring [DUE_DEPTH];
   int                    due_head;
   int                    due_tail;
   int                    due_count;
   int                    mismatches;
   int                    cycles;

   fixed_block_pool_allocator #(
      .MAX_PAGES          (MAX_PAGES),
      .MAX_SLOTS_PER_PAGE (MAX_SLOTS_PER_PAGE),
      .MAX_OBJECT_BYTES   (MAX_OBJECT_BYTES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_free_offset  (req_free_offset),
      .rsp_valid        (rsp_valid),
      .rsp_given_offset (rsp_given_offset),
      .rsp_status       (rsp_status),
      .rsp_outstanding  (rsp_outstanding),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1.0 clock = 1'b1;
      #1.0 clock = 1'b0;
   end

   function automatic int unsigned slot_bytes();
      int unsigned b;
      b = cfg_bytes;
      if (b == 0) b = 1;
      if (b > MAX_OBJECT_BYTES) b = MAX_OBJECT_BYTES;
      return b;
   endfunction

   function automatic int unsigned page_slots();
      int unsigned p;
      p = cfg_per;
      if (p == 0) p = 1;
      if (p > MAX_SLOTS_PER_PAGE) p = MAX_SLOTS_PER_PAGE;
      return p;
   endfunction

   function automatic void clear_pool();
      for (int i = 0; i < POOL_SLOTS; i++) slot_live[i] = 1'b0;
      freed_top  = 0;
      open_pages = 1;
      fresh_used = 0;
      live_slots = '0;
   endfunction

   // Applies one accepted word to the pool image and returns the reply it must produce.
   function automatic slot_reply_type pool_apply(input logic func,
                                                 input logic [OFF_W-1:0] off);
      int unsigned     bytes;
      int unsigned     per;
      int unsigned     idx;
      bit              have;
      bit              from_stack;
      bit              new_page;
      longint unsigned area;
      slot_reply_type  r;
      bytes      = slot_bytes();
      per        = page_slots();
      idx        = 0;
      have       = 1'b0;
      from_stack = 1'b0;
      new_page   = 1'b0;
      r.given    = '0;
      r.status   = STATUS_OK;
      if (func == FUNC_ALLOC) begin
         if (freed_top > 0) begin
            idx        = freed_slots[freed_top - 1];
            have       = 1'b1;
            from_stack = 1'b1;
         end else if (fresh_used < per) begin
            idx  = (open_pages - 1) * per + fresh_used;
            have = 1'b1;
         end else if (open_pages < MAX_PAGES) begin
            idx      = open_pages * per;
            have     = 1'b1;
            new_page = 1'b1;
         end
         if (have && (idx >= POOL_SLOTS ||
                      longint'(idx) * bytes > longint'(OFFSET_MASK)))
            have = 1'b0;
         if (!have) begin
            r.status = STATUS_EXHAUSTED;
         end else begin
            if (from_stack) begin
               freed_top--;
            end else if (new_page) begin
               open_pages++;
               fresh_used = 1;
            end else begin
               fresh_used++;
            end
            slot_live[idx] = 1'b1;
            live_slots     = live_slots + 1'b1;
            r.given        = OFF_W'(idx * bytes);
         end
      end else begin
         area = longint'(open_pages) * per * bytes;
         if (longint'(off) >= area || (off % bytes) != 0) begin
            r.status = STATUS_BAD_ADDR;
         end else begin
            idx = off / bytes;
            if (idx >= POOL_SLOTS) begin
               r.status = STATUS_BAD_ADDR;
            end else if (!slot_live[idx]) begin
               r.status = STATUS_DOUBLE_FREE;
            end else begin
               slot_live[idx] = 1'b0;
               if (freed_top < POOL_SLOTS) begin
                  freed_slots[freed_top] = idx[11:0];
                  freed_top++;
               end
               live_slots = live_slots - 1'b1;
            end
         end
      end
      r.outstanding = live_slots;
      return r;
   endfunction

   // Returns a random slot that is currently handed out, or -1 when none is.
   function automatic int pick_live_slot();
      int s;
      s = $urandom_range(0, POOL_SLOTS - 1);
      for (int k = 0; k < POOL_SLOTS; k++)
         if (slot_live[(s + k) % POOL_SLOTS]) return (s + k) % POOL_SLOTS;
      return -1;
   endfunction

   task automatic flag_mismatch(input string what, input logic [OFF_W-1:0] got,
                                input logic [OFF_W-1:0] want);
      if (mismatches < 50)
         $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                  want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      slot_reply_type want;
      slot_reply_type predicted;
      if (!reset) begin
         if (rsp_valid) begin
            if (due_count == 0) begin
               flag_mismatch("unexpected result word", rsp_given_offset, '0);
            end else begin
               want      = due_ring[due_head];
               due_head  = (due_head + 1) % DUE_DEPTH;
               due_count = due_count - 1;
               if (rsp_given_offset !== want.given)
                  flag_mismatch("given_offset", rsp_given_offset, want.given);
               if (rsp_status !== want.status)
                  flag_mismatch("status", OFF_W'(rsp_status), OFF_W'(want.status));
               if (rsp_outstanding !== want.outstanding)
                  flag_mismatch("outstanding", OFF_W'(rsp_outstanding),
                                OFF_W'(want.outstanding));
            end
         end
         if (start && !busy) begin
            predicted = pool_apply(req_func, req_free_offset);
            if (due_count == DUE_DEPTH) begin
               flag_mismatch("reply backlog", OFF_W'(due_count), '0);
            end else begin
               due_ring[due_tail] = typed_now ? typed_reply : predicted;
               due_tail           = (due_tail + 1) % DUE_DEPTH;
               due_count          = due_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("fixed_block_pool_allocator_test: FAIL");
         $finish;
      end
   end

   // Offers one word after an optional random gap and returns at the edge that takes it.
   task automatic issue_word(input logic func, input logic [OFF_W-1:0] off, input bit typed,
                             input slot_reply_type want, input int idle_pct);
      @(negedge clock);
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start           <= 1'b1;
      req_func        <= func;
      req_free_offset <= off;
      typed_now       <= typed;
      typed_reply     <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      start <= 1'b0;
      while (due_count != 0) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_OBJECT_BYTES) begin
         cfg_bytes = data;
         clear_pool();
      end else if (idx == REG_OBJECTS_PER_PAGE) begin
         cfg_per = data[PER_CFG_W-1:0];
         clear_pool();
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int              alloc_pct;
      int              idle_pct;
      int              slot;
      int unsigned     b;
      int unsigned     p;
      longint unsigned area;
      logic            func;
      logic [OFF_W-1:0] off;
      slot_reply_type  none;

      none            = '0;
      mismatches      = 0;
      cycles          = 0;
      due_head        = 0;
      due_tail        = 0;
      due_count       = 0;
      reset           = 1'b1;
      start           = 1'b0;
      req_func        = FUNC_ALLOC;
      req_free_offset = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      typed_now       = 1'b0;
      typed_reply     = '0;
      cfg_bytes       = OBJ_BYTES_RST;
      cfg_per         = PER_PAGE_RST;
      clear_pool();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (PLAN[i].is_csr)
            write_reg(PLAN[i].csr_idx, PLAN[i].csr_data);
         else
            issue_word(PLAN[i].func, PLAN[i].off, PLAN[i].typed, PLAN[i].reply, 0);
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_reg(REG_OBJECT_BYTES, CSR_DATA_W'(PHASE_BYTES[ph]));
         // Upper data bits above the 9-bit register are set at random to show they drop.
         write_reg(REG_OBJECTS_PER_PAGE,
                   {4'($urandom()), PER_CFG_W'(PHASE_PER[ph])});
         if (ph == 5)
            write_reg(CSR_IDX_W'($urandom_range(REG_SPARE_FIRST, 255)),
                      CSR_DATA_W'($urandom()));
         alloc_pct = 50;
         idle_pct  = PHASE_IDLE[ph];
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Bursts that lean to allocates fill the pool, in small geometries up to exhaustion;
            // bursts that lean to frees drain it again.
            if (n % 25 == 0) begin
               case ($urandom_range(0, 2))
                  0:       alloc_pct = 15;
                  1:       alloc_pct = 50;
                  default: alloc_pct = 85;
               endcase
               idle_pct = ($urandom_range(0, 3) == 0) ? 0 : PHASE_IDLE[ph];
            end
            b    = slot_bytes();
            p    = page_slots();
            area = longint'(open_pages) * p * b;
            slot = pick_live_slot();
            func = FUNC_FREE;
            off  = OFF_W'($urandom());
            if ($urandom_range(0, 99) < alloc_pct) begin
               func = FUNC_ALLOC;
            end else begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5, 6: begin
                     if (slot >= 0) off = OFF_W'(slot * b);
                  end
                  7: off = OFF_W'($urandom_range(0, open_pages * p - 1) * b);
                  8: ;
                  default: begin
                     case ($urandom_range(0, 2))
                        0:       off = OFF_W'(area);
                        1:       off = OFF_W'(area - 1);
                        default: off = OFF_W'(area + b);
                     endcase
                  end
               endcase
            end
            issue_word(func, off, 1'b0, none, idle_pct);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (due_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("fixed_block_pool_allocator_test: PASS");
      else
         $display("fixed_block_pool_allocator_test: FAIL");
      $finish;
   end

endmodule

/* files.f */
src/fbpa_pkg.sv
src/fbpa_ram.sv
src/fbpa_div.sv
src/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_test.sv
